@@ design/pcrh_pkg.sv @@
// Shared types and constants of the pair-count radial histogram block.
`timescale 1ns / 1ps
`default_nettype none

package pcrh_pkg;

  // Default sizes
  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned NUM_BINS_DEF   = 256;

  // Field widths
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned SQ_W      = 50;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned PC_W      = 9;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_INIT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    OP_LOAD_POINT = 3'd0,
    OP_LOAD_EDGE  = 3'd1,
    OP_RUN        = 3'd2,
    OP_READ_POINT = 3'd3,
    OP_READ_STATS = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PRD,
    ST_DGO,
    ST_DWAIT,
    ST_NWI,
    ST_NWJ,
    ST_SCAN,
    ST_HRI,
    ST_HWI,
    ST_HRJ,
    ST_HWJ,
    ST_RDP,
    ST_STAT
  } state_e;

  // One stored point
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [COUNT_W-1:0]        lim;
  } point_t;

  // One result beat
  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [SQ_W-1:0]    nearest_sq;
    logic [PC_W-1:0]    points_used;
    logic [SUM_W-1:0]   sphere_sum;
    logic [SUM_W-1:0]   shell_sum;
    logic               done;
  } res_t;

endpackage

`default_nettype wire

@@ design/pair_count_radial_histogram.sv @@
// Top level: point, edge, histogram and nearest-value memories with their sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Pair-count radial histogram. Load point, load edge and unknown operations
// stream back to back while the result output is not stalled. A point-bin
// read makes one histogram and one nearest-memory read. A bin-statistics read
// walks bins 0..bin of each of the n used points, one histogram entry read per
// cycle. A run first sweeps the histogram memory, one entry a cycle, over
// MAX_POINTS' * NUM_BINS' entries (each rounded up to a power of two; 65536 at
// the defaults), loading the nearest values on the way; then each unordered
// pair goes through the distance pipeline, the read-modify-write of the
// nearest entries, an edge-table scan that reads one edge per cycle and the
// read-modify-write of the histogram entries. After reset the same sweep runs
// once while no item is taken; configuration writes are taken at any time.
module pair_count_radial_histogram
  import pcrh_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned NUM_BINS   = NUM_BINS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [SQ_W-1:0]           cfg_data_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                operation_i,
  input  logic [7:0]                item_index_i,
  input  logic [7:0]                read_bin_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic [COUNT_W-1:0]        limit_bin_i,
  input  logic [SQ_W-1:0]           edge_sq_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [COUNT_W-1:0]        bin_count_o,
  output logic [SQ_W-1:0]           nearest_sq_o,
  output logic [PC_W-1:0]           points_used_o,
  output logic [SUM_W-1:0]          sphere_sum_o,
  output logic [SUM_W-1:0]          shell_sum_o,
  output logic                      done_res_o
);

  localparam int unsigned PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned BW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CW    = PW + BW;
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned NPT   = 1 << PW;
  localparam int unsigned NBN   = 1 << BW;
  localparam int unsigned NHIST = 1 << CW;

  // Configuration registers
  logic [PC_W-1:0] pc_q;
  logic [SQ_W-1:0] ninit_q;

  // Sequencer state
  state_e          state_q, state_d;
  logic            rst_pass_q, rst_pass_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   pi_q, pi_d, pj_q, pj_d, n_q, n_d;
  logic [BW-1:0]   bin_q, bin_d, cmp_k_q, cmp_k_d, sidx_q, sidx_d;
  logic            cmp_vld_q, cmp_vld_d, st_vld_q, st_vld_d, st_last_q, st_last_d;
  logic            rb_ok_q, rb_ok_d;
  logic [SQ_W-1:0] dist_q, dist_d;
  logic [PC_W-1:0] used_q, used_d;
  logic [SUM_W-1:0] sphere_q, sphere_d, shell_q, shell_d;

  // Output register
  logic            out_valid_q;
  res_t            res_q, res_d;
  logic            res_we;

  // Memories
  point_t             pt_mem [NPT];
  logic [SQ_W-1:0]    edge_mem [NBN];
  logic [COUNT_W-1:0] hist_mem [NHIST];
  logic [SQ_W-1:0]    near_mem [NPT];

  point_t             pt_a_q, pt_b_q, pt_wr;
  logic [SQ_W-1:0]    edge_q, near_a_q, near_b_q;
  logic [COUNT_W-1:0] hist_q;

  logic               pt_we, edge_we, hist_we, near_we;
  logic [CW-1:0]      hist_waddr, hist_raddr;
  logic [COUNT_W-1:0] hist_wdata;
  logic [PW-1:0]      near_waddr, near_raddr_a;
  logic [SQ_W-1:0]    near_wdata;

  // Distance unit
  logic               dist_go, dist_vld;
  logic [SQ_W-1:0]    dist_w;

  // Input decode
  logic               accept;
  logic               idx_pt_ok, idx_bin_ok, rb_ok;
  logic [PW-1:0]      idx_pt;
  logic [BW-1:0]      idx_bn, rb_bn;
  logic [NW-1:0]      n_eff;
  logic               issue;

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [COUNT_W-1:0] b);
    logic [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  assign accept     = in_valid_i && !in_stall_o;
  assign idx_pt_ok  = 32'(item_index_i) < MAX_POINTS;
  assign idx_bin_ok = 32'(item_index_i) < NUM_BINS;
  assign rb_ok      = 32'(read_bin_i) < NUM_BINS;
  assign idx_pt     = PW'(item_index_i);
  assign idx_bn     = BW'(item_index_i);
  assign rb_bn      = BW'(read_bin_i);
  assign n_eff      = (32'(pc_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(pc_q);
  assign pt_wr      = '{x: coord_x_i, y: coord_y_i, z: coord_z_i, lim: limit_bin_i};

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  assign bin_count_o   = res_q.bin_count;
  assign nearest_sq_o  = res_q.nearest_sq;
  assign points_used_o = res_q.points_used;
  assign sphere_sum_o  = res_q.sphere_sum;
  assign shell_sum_o   = res_q.shell_sum;
  assign done_res_o    = res_q.done;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      ninit_q <= SQ_MAX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT:    pc_q    <= cfg_data_i[PC_W-1:0];
        CFG_NEIGHBOUR_INIT: ninit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcrh_sqdist u_sqdist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (dist_go),
    .a_i     (pt_a_q),
    .b_i     (pt_b_q),
    .valid_o (dist_vld),
    .dist_o  (dist_w)
  );

  // Sequencer: next state and memory controls
  always_comb begin
    state_d      = state_q;
    rst_pass_d   = rst_pass_q;
    cnt_d        = cnt_q;
    pi_d         = pi_q;
    pj_d         = pj_q;
    n_d          = n_q;
    bin_d        = bin_q;
    cmp_vld_d    = 1'b0;
    cmp_k_d      = cmp_k_q;
    sidx_d       = sidx_q;
    st_vld_d     = 1'b0;
    st_last_d    = st_last_q;
    rb_ok_d      = rb_ok_q;
    dist_d       = dist_q;
    used_d       = used_q;
    sphere_d     = sphere_q;
    shell_d      = shell_q;
    res_we       = 1'b0;
    res_d        = '0;
    res_d.done   = 1'b1;
    pt_we        = 1'b0;
    edge_we      = 1'b0;
    hist_we      = 1'b0;
    hist_waddr   = {pi_q[PW-1:0], bin_q};
    hist_wdata   = hist_q + COUNT_W'(1);
    hist_raddr   = {pi_q[PW-1:0], cnt_q[BW-1:0]};
    near_we      = 1'b0;
    near_waddr   = pi_q[PW-1:0];
    near_wdata   = (dist_q < near_a_q) ? dist_q : near_a_q;
    near_raddr_a = pi_q[PW-1:0];
    dist_go      = 1'b0;
    issue        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        near_raddr_a = idx_pt;
        hist_raddr   = {idx_pt, rb_bn};
        if (accept) begin
          case (op_e'(operation_i))
            OP_LOAD_POINT: begin
              pt_we  = idx_pt_ok;
              res_we = 1'b1;
            end
            OP_LOAD_EDGE: begin
              edge_we = idx_bin_ok;
              res_we  = 1'b1;
            end
            OP_RUN: begin
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_READ_POINT: begin
              if (idx_pt_ok) begin
                rb_ok_d = rb_ok;
                state_d = ST_RDP;
              end else begin
                res_we = 1'b1;
              end
            end
            OP_READ_STATS: begin
              if (idx_bin_ok) begin
                pi_d     = '0;
                cnt_d    = '0;
                n_d      = n_eff;
                sidx_d   = idx_bn;
                used_d   = '0;
                sphere_d = '0;
                shell_d  = '0;
                state_d  = ST_STAT;
              end else begin
                res_we = 1'b1;
              end
            end
            default: begin
              res_d.done = 1'b0;
              res_we     = 1'b1;
            end
          endcase
        end
      end

      // Histogram sweep, nearest values loaded in the first rows
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = cnt_q;
        hist_wdata = '0;
        if (cnt_q[CW-1:PW] == '0) begin
          near_we    = 1'b1;
          near_waddr = cnt_q[PW-1:0];
          near_wdata = rst_pass_q ? SQ_MAX : ninit_q;
        end
        cnt_d = cnt_q + CW'(1);
        if (&cnt_q) begin
          if (rst_pass_q) begin
            rst_pass_d = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            n_d  = n_eff;
            pi_d = '0;
            pj_d = NW'(1);
            if (n_eff < NW'(2)) begin
              res_we  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_PRD;
            end
          end
        end
      end

      ST_PRD: state_d = ST_DGO;

      ST_DGO: begin
        dist_go = 1'b1;
        state_d = ST_DWAIT;
      end

      ST_DWAIT: begin
        if (dist_vld) begin
          dist_d  = dist_w;
          state_d = ST_NWI;
        end
      end

      ST_NWI: begin
        near_we = 1'b1;
        state_d = ST_NWJ;
      end

      ST_NWJ: begin
        near_we    = 1'b1;
        near_waddr = pj_q[PW-1:0];
        near_wdata = (dist_q < near_b_q) ? dist_q : near_b_q;
        cnt_d      = '0;
        bin_d      = '0;
        state_d    = ST_SCAN;
      end

      // One edge read per cycle, compared in the next cycle
      ST_SCAN: begin
        issue = 32'(cnt_q) < NUM_BINS;
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
        end
        cmp_vld_d = issue;
        cmp_k_d   = cnt_q[BW-1:0];
        if (cmp_vld_q && (edge_q <= dist_q)) begin
          bin_d = cmp_k_q;
        end
        if (!issue && !cmp_vld_q) begin
          state_d = ST_HRI;
        end
      end

      ST_HRI: begin
        hist_raddr = {pi_q[PW-1:0], bin_q};
        state_d    = ST_HWI;
      end

      ST_HWI: begin
        hist_we = (32'(bin_q) < 32'(pt_a_q.lim)) && (hist_q != '1);
        state_d = ST_HRJ;
      end

      ST_HRJ: begin
        hist_raddr = {pj_q[PW-1:0], bin_q};
        state_d    = ST_HWJ;
      end

      ST_HWJ: begin
        hist_waddr = {pj_q[PW-1:0], bin_q};
        hist_we    = (32'(bin_q) < 32'(pt_b_q.lim)) && (hist_q != '1);
        if ((pj_q + NW'(1)) < n_q) begin
          pj_d    = pj_q + NW'(1);
          state_d = ST_PRD;
        end else if ((pi_q + NW'(2)) < n_q) begin
          pi_d    = pi_q + NW'(1);
          pj_d    = pi_q + NW'(2);
          state_d = ST_PRD;
        end else begin
          res_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_RDP: begin
        res_d.bin_count  = rb_ok_q ? hist_q : '0;
        res_d.nearest_sq = near_a_q;
        res_we           = 1'b1;
        state_d          = ST_IDLE;
      end

      // Walk bins 0..idx of every used point
      ST_STAT: begin
        issue = pi_q < n_q;
        if (issue) begin
          st_vld_d  = 1'b1;
          st_last_d = (cnt_q[BW-1:0] == sidx_q);
          if (cnt_q[BW-1:0] == sidx_q) begin
            cnt_d = '0;
            pi_d  = pi_q + NW'(1);
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
        if (st_vld_q && (32'(pt_a_q.lim) > 32'(sidx_q))) begin
          sphere_d = sat_add(sphere_q, hist_q);
          if (st_last_q) begin
            shell_d = sat_add(shell_q, hist_q);
            used_d  = (used_q == '1) ? used_q : used_q + PC_W'(1);
          end
        end
        if (!issue && !st_vld_q) begin
          res_d.points_used = used_q;
          res_d.sphere_sum  = sphere_q;
          res_d.shell_sum   = shell_q;
          res_we            = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rst_pass_q  <= 1'b1;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      st_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rst_pass_q  <= rst_pass_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      st_vld_q    <= st_vld_d;
      out_valid_q <= res_we || (out_valid_q && out_stall_i);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pi_q      <= pi_d;
    pj_q      <= pj_d;
    n_q       <= n_d;
    bin_q     <= bin_d;
    cmp_k_q   <= cmp_k_d;
    sidx_q    <= sidx_d;
    st_last_q <= st_last_d;
    rb_ok_q   <= rb_ok_d;
    dist_q    <= dist_d;
    used_q    <= used_d;
    sphere_q  <= sphere_d;
    shell_q   <= shell_d;
    if (res_we) begin
      res_q <= res_d;
    end
  end

  // Point memory: one write, two reads
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[idx_pt] <= pt_wr;
    end
    pt_a_q <= pt_mem[pi_q[PW-1:0]];
    pt_b_q <= pt_mem[pj_q[PW-1:0]];
  end

  // Edge table
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[idx_bn] <= edge_sq_i;
    end
    edge_q <= edge_mem[cnt_q[BW-1:0]];
  end

  // Histogram memory
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  // Nearest-value memory: one write, two reads
  always_ff @(posedge clk_i) begin
    if (near_we) begin
      near_mem[near_waddr] <= near_wdata;
    end
    near_a_q <= near_mem[near_raddr_a];
    near_b_q <= near_mem[pj_q[PW-1:0]];
  end

`ifndef SYNTHESIS
  // No histogram write while waiting for items
  a_idle_no_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hist_we)
    else $error("histogram written while idle");

  // Second point of a pair is always above the first
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HWJ) |-> (pj_q > pi_q))
    else $error("pair indexes out of order");

  // Distance results arrive only while waited for
  a_dist_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_vld |-> (state_q == ST_DWAIT))
    else $error("unexpected distance result");

  // A result is never loaded over one still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten");
`endif

endmodule

`default_nettype wire

@@ design/pcrh_sqdist.sv @@
// Three-stage pipeline forming the exact squared distance of two points.
`timescale 1ns / 1ps
`default_nettype none

module pcrh_sqdist
  import pcrh_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  point_t          a_i,
  input  point_t          b_i,
  output logic            valid_o,
  output logic [SQ_W-1:0] dist_o
);

  localparam int unsigned PROD_W = 2 * COORD_W;

  logic [2:0]              vld_q;
  logic [COORD_W-1:0]      mx_q, my_q, mz_q;
  logic [PROD_W-1:0]       sx_q, sy_q, sz_q;
  logic [SQ_W-1:0]         sum_q;

  // |a - b| fits in COORD_W bits unsigned
  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] m;
    d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
    m = d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
    return m[COORD_W-1:0];
  endfunction

  // Valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], go_i};
    end
  end

  // Differences, squares, sum
  always_ff @(posedge clk_i) begin
    mx_q  <= abs_diff(a_i.x, b_i.x);
    my_q  <= abs_diff(a_i.y, b_i.y);
    mz_q  <= abs_diff(a_i.z, b_i.z);
    sx_q  <= PROD_W'(mx_q) * PROD_W'(mx_q);
    sy_q  <= PROD_W'(my_q) * PROD_W'(my_q);
    sz_q  <= PROD_W'(mz_q) * PROD_W'(mz_q);
    sum_q <= SQ_W'(sx_q) + SQ_W'(sy_q) + SQ_W'(sz_q);
  end

  assign valid_o = vld_q[2];
  assign dist_o  = sum_q;

endmodule

`default_nettype wire
